// ===== rtl/glyph_to_framebuffer_writer_top_assert.svh =====
// Assertion macros for the glyph to framebuffer writer.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef GLYPH_TO_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH
`define GLYPH_TO_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GFW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gfw_pkg.sv =====
// Package for the glyph to framebuffer writer: sizes, codes, state type and
// the color byte-order helper. No dependencies.
`timescale 1ns / 1ps

package gfw_pkg;

   // Font geometry.
   localparam int GLYPH_ROWS    = 16;
   localparam int CHAR_CODES    = 256;
   localparam int STORE_DEPTH   = 4096;
   localparam int STORE_AW      = 12;
   localparam int FONT_ENTRIES  = CHAR_CODES * GLYPH_ROWS;
   localparam int ROW_W         = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam int PAIRS_PER_ROW = 4;
   localparam int PAIR_W        = 2;

   // Field widths.
   localparam int CODE_W  = 8;
   localparam int POS_W   = 12;
   localparam int COLOR_W = 32;
   localparam int WIDTH_W = 13;
   localparam int ADDR_W  = 32;

   // Item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PIXELS = 2'd1;
   localparam logic [WIDTH_W-1:0]     ROW_PIXELS_RESET = 13'd640;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_BASE,
      S_RUN
   } gfw_state_type;

   // RGBA word to the B,G,R,A in-memory byte order.
   function automatic logic [COLOR_W-1:0] to_bgra(input logic [COLOR_W-1:0] rgba);
      return {rgba[7:0], rgba[31:24], rgba[23:16], rgba[15:8]};
   endfunction

endpackage

// ===== rtl/glyph_to_framebuffer_writer_top.sv =====
// Glyph to framebuffer writer: draws 8-pixel-wide bitmap characters as
// two-pixel framebuffer writes. A draw passes through the multiply and base
// setup states, then issues 64 writes at one per cycle unless the result channel
// stalls, with one font store read per glyph row.
// Synchronous active-high reset clears control state and the configuration
// registers; the font store is undefined until loaded and gets no clearing pass.
`timescale 1ns / 1ps
`include "glyph_to_framebuffer_writer_top_assert.svh"

module glyph_to_framebuffer_writer_top
   import gfw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [STORE_AW-1:0]    req_font_slot,
   input  logic [7:0]             req_font_bits,
   input  logic [CODE_W-1:0]      req_char_code,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,
   input  logic [COLOR_W-1:0]     req_back_color,
   input  logic [COLOR_W-1:0]     req_fore_color,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_W-1:0]      rsp_write_addr,
   output logic [2*COLOR_W-1:0]   rsp_pixel_pair,
   output logic                   rsp_last_write,
   // Configuration port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'(CHAR_CODES - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(GLYPH_ROWS - 1);
   localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS_PER_ROW - 1);

   // Registers
   gfw_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]      frame_base_ff;
   logic [WIDTH_W-1:0]     row_pixels_ff;
   logic [CODE_W-1:0]      code_ff, code_in;
   logic [POS_W-1:0]       pos_x_ff, pos_x_in;
   logic [POS_W-1:0]       pos_y_ff, pos_y_in;
   logic [COLOR_W-1:0]     back_ff, back_in;
   logic [COLOR_W-1:0]     fore_ff, fore_in;
   logic [ADDR_W-1:0]      mul_ff, mul_in;
   logic [ADDR_W-1:0]      line_ff, line_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [PAIR_W-1:0]      pair_ff, pair_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [2*COLOR_W-1:0]   rsp_pixels_ff, rsp_pixels_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Font store and its read data register
   logic [7:0]             font_store_ff [STORE_DEPTH];
   logic [7:0]             font_rd_ff;

   // Memory port controls
   logic                   mem_we;
   logic [STORE_AW-1:0]    mem_waddr;
   logic                   mem_re;
   logic [STORE_AW-1:0]    mem_raddr;
   logic [ROW_W-1:0]       rd_row;

   // Datapath helpers
   logic                   req_fire;
   logic                   out_load;
   logic [ADDR_W-1:0]      py_m1;
   logic [ADDR_W-1:0]      px_off;
   logic [ADDR_W-1:0]      stride;
   logic [2:0]             bit_left;
   logic [2:0]             bit_right;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign py_m1     = ADDR_W'(pos_y_ff) - ADDR_W'(1);
   assign px_off    = (ADDR_W'(pos_x_ff) - ADDR_W'(1)) << 2;
   assign stride    = ADDR_W'(row_pixels_ff) << 2;
   assign bit_left  = {pair_ff, 1'b0};
   assign bit_right = {pair_ff, 1'b1};

   // The output register can take a new beat when it is empty or being drained.
   assign out_load  = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_ready);

   // Next state, counters, result beat and memory port controls.
   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      back_in       = back_ff;
      fore_in       = fore_ff;
      mul_in        = mul_ff;
      line_in       = line_ff;
      row_in        = row_ff;
      pair_in       = pair_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pixels_in = rsp_pixels_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = req_font_slot;
      mem_re        = 1'b0;
      rd_row        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_LOAD) begin
                  // Slots past the font are dropped.
                  mem_we = ({1'b0, req_font_slot} < (STORE_AW + 1)'(FONT_ENTRIES));
               end else begin
                  code_in  = req_char_code & CODE_MASK;
                  pos_x_in = req_pos_x;
                  pos_y_in = req_pos_y;
                  back_in  = to_bgra(req_back_color);
                  fore_in  = to_bgra(req_fore_color);
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // Row offset of the top glyph row, in pixels, modulo 2^32.
            mul_in   = py_m1 * ADDR_W'(row_pixels_ff);
            state_in = S_BASE;
         end
         S_BASE: begin
            // Byte address of the top-left pixel, and the fetch of the top row.
            line_in  = frame_base_ff + px_off + (mul_ff << 2);
            row_in   = '0;
            pair_in  = '0;
            mem_re   = 1'b1;
            rd_row   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = line_ff + ADDR_W'({pair_ff, 3'b000});
               rsp_pixels_in = {font_rd_ff[bit_right] ? fore_ff : back_ff,
                                font_rd_ff[bit_left]  ? fore_ff : back_ff};
               rsp_last_in   = (row_ff == LAST_ROW) && (pair_ff == LAST_PAIR);
               if (pair_ff == LAST_PAIR) begin
                  pair_in = '0;
                  if (row_ff == LAST_ROW) begin
                     row_in   = '0;
                     state_in = S_IDLE;
                  end else begin
                     // Move down one framebuffer line and fetch the next row.
                     row_in  = row_ff + ROW_W'(1);
                     line_in = line_ff + stride;
                     mem_re  = 1'b1;
                     rd_row  = row_ff + ROW_W'(1);
                  end
               end else begin
                  pair_in = pair_ff + PAIR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      mem_raddr = STORE_AW'(int'(code_ff) * GLYPH_ROWS + int'(rd_row));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         pair_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         pair_ff      <= pair_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         row_pixels_ff <= ROW_PIXELS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_BASE: frame_base_ff <= csr_wdata;
            CSR_ROW_PIXELS: row_pixels_ff <= csr_wdata[WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      back_ff       <= back_in;
      fore_ff       <= fore_in;
      mul_ff        <= mul_in;
      line_ff       <= line_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Font store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_store_ff[mem_waddr] <= req_font_bits;
      end
      if (mem_re) begin
         font_rd_ff <= font_store_ff[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_addr = rsp_addr_ff;
   assign rsp_pixel_pair = rsp_pixels_ff;
   assign rsp_last_write = rsp_last_ff;

   // A draw beat always starts the address setup.
   `GFW_ASSERT_NEXT(a_draw_starts, req_fire && (req_mode == MODE_DRAW), state_ff == S_MUL, "draw beat did not start setup")

   // The final write of a glyph returns the sequencer to idle.
   `GFW_ASSERT_NEXT(a_last_ends, out_load && (row_ff == LAST_ROW) && (pair_ff == LAST_PAIR), state_ff == S_IDLE, "sequencer did not stop after the last write")

   // While a final write waits, the row and pair counters are back at the top.
   `GFW_ASSERT_NOW(a_last_counters, rsp_valid_ff && rsp_last_ff, (row_ff == '0) && (pair_ff == '0), "counters not cleared after the last write")

endmodule
